FILE: rtl/kot_pkg.sv
// Shared types, codes and keyword table for the keyword opcode tokenizer.
package kot_pkg;

    localparam int TOKEN_MAX   = 6;
    localparam int KW_COUNT    = 9;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] OP_LOOP_OPEN  = 4'd6;
    localparam logic [3:0] OP_LOOP_CLOSE = 4'd7;

    localparam logic [1:0] KIND_OPCODE = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_INVALID   = 2'd0;
    localparam logic [1:0] ERR_TOO_DEEP  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    localparam logic [7:0] CH_END       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_SEMICOLON = 8'h3b;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Byte 0 of each keyword sits in the low bits; unused bytes are zero.
    localparam logic [KW_COUNT-1:0][TOKEN_MAX*8-1:0] KW_TABLE = {
        48'h6f_6f_74_6e_65_67,
        48'h00_00_00_79_61_77,
        48'h00_00_00_65_68_74,
        48'h00_00_00_00_79_62,
        48'h00_00_00_77_74_62,
        48'h00_78_75_6e_69_6c,
        48'h00_00_68_63_72_61,
        48'h00_00_00_65_73_75,
        48'h00_00_00_00_00_69
    };

    typedef struct packed {
        logic       op_valid;
        logic [3:0] op;
        logic       err_valid;
        logic [1:0] err_code;
        logic       end_flag;
    } ev_ctrl_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } kw_match_t;

    function automatic kw_match_t kw_lookup(input logic [TOKEN_MAX*8-1:0] text);
        kw_match_t m;
        m.hit = 1'b0;
        m.idx = 4'd0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (text == KW_TABLE[k])
            begin
                m.hit = 1'b1;
                m.idx = 4'(k);
            end
        end
        return m;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

endpackage

FILE: rtl/kot_front.sv
// Front end: scans source bytes, tracks position and nesting, and posts events.
module kot_front
    import kot_pkg::*;
#(
    parameter int STACK_SIZE    = 256,
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               character,
    output logic                     ev_push,
    output ev_ctrl_t                 ev_ctrl,
    output logic [POSITION_BITS-1:0] ev_line,
    output logic [POSITION_BITS-1:0] ev_column
);

    localparam int DEPTH_BITS = (STACK_SIZE > 2) ? $clog2(STACK_SIZE) : 1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(STACK_SIZE - 1);
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic [TOKEN_MAX-1:0][7:0] tok_bytes_reg, tok_bytes_next;
    logic [2:0]                tok_len_reg, tok_len_next;
    logic                      overlong_reg, overlong_next;
    logic                      in_token_reg, in_token_next;
    logic                      in_comment_reg, in_comment_next;
    logic                      halted_reg, halted_next;
    logic [POSITION_BITS-1:0]  cur_line_reg, cur_line_next;
    logic [POSITION_BITS-1:0]  cur_col_reg, cur_col_next;
    logic [POSITION_BITS-1:0]  start_line_reg, start_line_next;
    logic [POSITION_BITS-1:0]  start_col_reg, start_col_next;
    logic [DEPTH_BITS-1:0]     depth_reg, depth_next;

    kw_match_t match;

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    assign match = kw_lookup(tok_bytes_reg);

    always_comb
    begin
        logic done;
        logic go_reset;
        done            = 1'b0;
        go_reset        = 1'b0;
        tok_bytes_next  = tok_bytes_reg;
        tok_len_next    = tok_len_reg;
        overlong_next   = overlong_reg;
        in_token_next   = in_token_reg;
        in_comment_next = in_comment_reg;
        halted_next     = halted_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        depth_next      = depth_reg;
        ev_ctrl         = '0;
        ev_line         = start_line_reg;
        ev_column       = start_col_reg;

        if (accept)
        begin
            if (halted_reg)
            begin
                done = 1'b1;
                if (character == CH_END)
                begin
                    go_reset = 1'b1;
                end
            end
            else if (in_token_reg)
            begin
                if (is_letter(character))
                begin
                    done = 1'b1;
                    if (tok_len_reg < 3'(TOKEN_MAX))
                    begin
                        tok_bytes_next[tok_len_reg] = character;
                        tok_len_next = tok_len_reg + 3'd1;
                    end
                    else
                    begin
                        overlong_next = 1'b1;
                    end
                    cur_col_next = pos_inc(cur_col_reg);
                end
                else
                begin
                    in_token_next = 1'b0;
                    if (overlong_reg || !match.hit)
                    begin
                        ev_ctrl.err_valid = 1'b1;
                        ev_ctrl.err_code  = ERR_INVALID;
                    end
                    else if (match.idx == OP_LOOP_OPEN && depth_reg == DEPTH_MAX)
                    begin
                        ev_ctrl.err_valid = 1'b1;
                        ev_ctrl.err_code  = ERR_TOO_DEEP;
                    end
                    else if (match.idx == OP_LOOP_CLOSE && depth_reg == '0)
                    begin
                        ev_ctrl.err_valid = 1'b1;
                        ev_ctrl.err_code  = ERR_UNMATCHED;
                    end
                    else
                    begin
                        ev_ctrl.op_valid = 1'b1;
                        ev_ctrl.op       = match.idx;
                        if (match.idx == OP_LOOP_OPEN)
                        begin
                            depth_next = depth_reg + 1'b1;
                        end
                        else if (match.idx == OP_LOOP_CLOSE)
                        begin
                            depth_next = depth_reg - 1'b1;
                        end
                    end
                    if (ev_ctrl.err_valid)
                    begin
                        done        = 1'b1;
                        halted_next = 1'b1;
                        if (character == CH_END)
                        begin
                            go_reset = 1'b1;
                        end
                    end
                end
            end

            if (!done)
            begin
                if (character == CH_END)
                begin
                    ev_ctrl.end_flag = 1'b1;
                    go_reset = 1'b1;
                end
                else if (in_comment_reg && character != CH_NEWLINE)
                begin
                    cur_col_next = pos_inc(cur_col_reg);
                end
                else
                begin
                    in_comment_next = 1'b0;
                    cur_col_next    = pos_inc(cur_col_reg);
                    if (character == CH_NEWLINE)
                    begin
                        cur_line_next = pos_inc(cur_line_reg);
                        cur_col_next  = '0;
                    end
                    else if (is_space(character))
                    begin
                        cur_col_next = pos_inc(cur_col_reg);
                    end
                    else if (character == CH_SEMICOLON)
                    begin
                        in_comment_next = 1'b1;
                    end
                    else
                    begin
                        in_token_next     = 1'b1;
                        start_line_next   = cur_line_reg;
                        start_col_next    = pos_inc(cur_col_reg);
                        tok_bytes_next    = '0;
                        tok_bytes_next[0] = character;
                        tok_len_next      = 3'd1;
                        overlong_next     = 1'b0;
                    end
                end
            end

            if (go_reset)
            begin
                tok_bytes_next  = '0;
                tok_len_next    = 3'd0;
                overlong_next   = 1'b0;
                in_token_next   = 1'b0;
                in_comment_next = 1'b0;
                halted_next     = 1'b0;
                cur_line_next   = POS_ONE;
                cur_col_next    = '0;
                start_line_next = POS_ONE;
                start_col_next  = '0;
                depth_next      = '0;
            end
        end

        ev_push = ev_ctrl.op_valid || ev_ctrl.err_valid || ev_ctrl.end_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_bytes_reg  <= '0;
            tok_len_reg    <= 3'd0;
            overlong_reg   <= 1'b0;
            in_token_reg   <= 1'b0;
            in_comment_reg <= 1'b0;
            halted_reg     <= 1'b0;
            cur_line_reg   <= POS_ONE;
            cur_col_reg    <= '0;
            start_line_reg <= POS_ONE;
            start_col_reg  <= '0;
            depth_reg      <= '0;
        end
        else
        begin
            tok_bytes_reg  <= tok_bytes_next;
            tok_len_reg    <= tok_len_next;
            overlong_reg   <= overlong_next;
            in_token_reg   <= in_token_next;
            in_comment_reg <= in_comment_next;
            halted_reg     <= halted_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            depth_reg      <= depth_next;
        end
    end

endmodule

FILE: rtl/kot_queue.sv
// Short event queue between the front end and the result stage.
module kot_queue
    import kot_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  ev_ctrl_t                 push_ctrl,
    input  logic [POSITION_BITS-1:0] push_line,
    input  logic [POSITION_BITS-1:0] push_column,
    output logic                     full,
    input  logic                     pop,
    output logic                     empty,
    output ev_ctrl_t                 head_ctrl,
    output logic [POSITION_BITS-1:0] head_line,
    output logic [POSITION_BITS-1:0] head_column
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    ev_ctrl_t                 ctrl_mem [QUEUE_DEPTH];
    logic [POSITION_BITS-1:0] line_mem [QUEUE_DEPTH];
    logic [POSITION_BITS-1:0] col_mem  [QUEUE_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == (PTR_BITS + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign head_ctrl   = ctrl_mem[rd_ptr_reg];
    assign head_line   = line_mem[rd_ptr_reg];
    assign head_column = col_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_mem[wr_ptr_reg] <= push_ctrl;
            line_mem[wr_ptr_reg] <= push_line;
            col_mem[wr_ptr_reg]  <= push_column;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/kot_back.sv
// Result stage: expands queued events into result items held in an output register.
module kot_back
    import kot_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  ev_ctrl_t                 q_ctrl,
    input  logic [POSITION_BITS-1:0] q_line,
    input  logic [POSITION_BITS-1:0] q_column,
    output logic                     q_pop,
    output logic                     empty,
    input  logic                     pop,
    output logic [1:0]               kind,
    output logic [3:0]               opcode_value,
    output logic [1:0]               error_code,
    output logic [POSITION_BITS-1:0] token_line,
    output logic [POSITION_BITS-1:0] token_column,
    output logic                     final_item
);

    logic                     valid_reg, valid_next;
    logic                     pend_end_reg, pend_end_next;
    logic [1:0]               kind_reg, kind_next;
    logic [3:0]               op_reg, op_next;
    logic [1:0]               err_reg, err_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic                     fin_reg, fin_next;
    logic                     free;

    assign free = !valid_reg || pop;

    always_comb
    begin
        valid_next    = valid_reg;
        pend_end_next = pend_end_reg;
        kind_next     = kind_reg;
        op_next       = op_reg;
        err_next      = err_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        fin_next      = fin_reg;
        q_pop         = 1'b0;

        if (free)
        begin
            valid_next = 1'b0;
            if (pend_end_reg || (!q_empty && !q_ctrl.op_valid && !q_ctrl.err_valid))
            begin
                valid_next    = 1'b1;
                pend_end_next = 1'b0;
                q_pop         = !pend_end_reg;
                kind_next     = KIND_END;
                op_next       = 4'd0;
                err_next      = 2'd0;
                line_next     = '0;
                col_next      = '0;
                fin_next      = 1'b1;
            end
            else if (!q_empty)
            begin
                valid_next = 1'b1;
                q_pop      = 1'b1;
                line_next  = q_line;
                col_next   = q_column;
                if (q_ctrl.op_valid)
                begin
                    pend_end_next = q_ctrl.end_flag;
                    kind_next     = KIND_OPCODE;
                    op_next       = q_ctrl.op;
                    err_next      = 2'd0;
                    fin_next      = 1'b0;
                end
                else
                begin
                    kind_next = KIND_ERROR;
                    op_next   = 4'd0;
                    err_next  = q_ctrl.err_code;
                    fin_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pend_end_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            pend_end_reg <= pend_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        op_reg   <= op_next;
        err_reg  <= err_next;
        line_reg <= line_next;
        col_reg  <= col_next;
        fin_reg  <= fin_next;
    end

    assign empty        = !valid_reg;
    assign kind         = kind_reg;
    assign opcode_value = op_reg;
    assign error_code   = err_reg;
    assign token_line   = line_reg;
    assign token_column = col_reg;
    assign final_item   = fin_reg;

endmodule

FILE: rtl/keyword_opcode_tokenizer.sv
// Top level of the keyword opcode tokenizer.
//
//  Channel   Handshake         Request contents
//  input     push / full       character
//  result    empty / pop       kind, opcode_value, error_code, token_line,
//                              token_column, final_item
//
// One source byte is taken per cycle while the event queue has room.
// A result passes through the event queue before it reaches the output register.
// An end byte after a valid token yields two results, the opcode and then the end item.
// Reset clears the scanner state, the queue and the output register's valid flag.
// A held result stalls only the queue; the scanner stops when the queue is full.
module keyword_opcode_tokenizer
    import kot_pkg::*;
#(
    parameter int STACK_SIZE    = 256,
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               character,
    output logic                     empty,
    input  logic                     pop,
    output logic [1:0]               kind,
    output logic [3:0]               opcode_value,
    output logic [1:0]               error_code,
    output logic [POSITION_BITS-1:0] token_line,
    output logic [POSITION_BITS-1:0] token_column,
    output logic                     final_item
);

    logic                     ev_push;
    ev_ctrl_t                 ev_ctrl;
    logic [POSITION_BITS-1:0] ev_line, ev_column;
    logic                     q_full, q_empty, q_pop;
    ev_ctrl_t                 q_ctrl;
    logic [POSITION_BITS-1:0] q_line, q_column;

    assign full = q_full;

    kot_front #(
        .STACK_SIZE    (STACK_SIZE),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push && !q_full),
        .character (character),
        .ev_push   (ev_push),
        .ev_ctrl   (ev_ctrl),
        .ev_line   (ev_line),
        .ev_column (ev_column)
    );

    kot_queue #(
        .POSITION_BITS (POSITION_BITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (ev_push),
        .push_ctrl   (ev_ctrl),
        .push_line   (ev_line),
        .push_column (ev_column),
        .full        (q_full),
        .pop         (q_pop),
        .empty       (q_empty),
        .head_ctrl   (q_ctrl),
        .head_line   (q_line),
        .head_column (q_column)
    );

    kot_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_ctrl       (q_ctrl),
        .q_line       (q_line),
        .q_column     (q_column),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .opcode_value (opcode_value),
        .error_code   (error_code),
        .token_line   (token_line),
        .token_column (token_column),
        .final_item   (final_item)
    );

endmodule
